// ----- rtl/core/lri_pkg.sv -----
// lri_pkg: shared widths, constants, payload and control types for the
// linear interpolation resampler. No dependencies.
package lri_pkg;

    // fixed point and sample widths
    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int STEP_W      = 20;
    localparam int POS_W       = FRAC_BITS + 4;
    localparam int PHASE_W     = FRAC_BITS + 3;
    localparam int CMP_W       = (STEP_W > POS_W) ? STEP_W : POS_W;
    localparam int PROD_W      = SAMPLE_BITS + FRAC_BITS + 1;

    // register port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // positions
    localparam logic [POS_W-1:0] ONE_POS = POS_W'(1) << FRAC_BITS;
    localparam logic [POS_W-1:0] TWO_POS = POS_W'(2) << FRAC_BITS;

    // step limits, 1/8 and 8
    localparam logic [CMP_W-1:0] STEP_MIN = CMP_W'(1) << (FRAC_BITS - 3);
    localparam logic [CMP_W-1:0] STEP_MAX = CMP_W'(1) << (FRAC_BITS + 3);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(ONE_POS);

    // register indexes, decoded from the word address
    localparam logic [0:0] REG_STEP   = 1'b0;
    localparam logic [0:0] REG_STEREO = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t left_in;
        sample_t right_in;
        logic    final_frame;
    } frame_t;

    typedef struct packed {
        sample_t left_out;
        sample_t right_out;
        logic    run_end;
        logic    stream_end;
    } result_t;

    // settings seen by the datapath
    typedef struct packed {
        logic [POS_W-1:0] step;
        logic             stereo;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPAN,
        ST_TAIL
    } state_t;

endpackage

// ----- rtl/core/linear_interp_resampler_top.sv -----
// linear_interp_resampler_top: frame sequencer, two interpolation lanes and
// the merging output register. Depends on lri_pkg, lri_cfg, lri_lane.
//
//   channel   direction  handshake            word
//   frame     in         frame_valid/ready    frame_t (left_in, right_in, final_frame)
//   result    out        result_valid/ready   result_t (left_out, right_out, flags)
//   config    in         psel/penable/pready  step at 0x0, stereo at 0x4
//
// a frame is taken in ST_IDLE, then the sequencer issues one result word
// per cycle unless the result port stalls; closing the span is a step of
// its own, and closing the tail of a final frame another. a frame makes at
// most 16 results; the first frame of a stream that is not final is only
// held and makes none.
// results pass the multiply register, then the output register.
// a stalled result port holds the sequencer; a new frame is taken while
// earlier words still drain. reset clears all stream state, no clearing pass.
module linear_interp_resampler_top
    import lri_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_valid,
    output logic              frame_ready,
    input  frame_t            frame_data,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t cfg;

    state_t               state_reg,      state_next;
    logic [POS_W-1:0]     pos_reg,        pos_next;
    logic [PHASE_W-1:0]   phase_reg,      phase_next;
    logic                 have_held_reg,  have_held_next;
    sample_t              held_l_reg,     held_l_next;
    sample_t              held_r_reg,     held_r_next;
    sample_t              pre_l_reg,      pre_l_next;
    sample_t              pre_r_reg,      pre_r_next;
    sample_t              cur_l_reg,      cur_l_next;
    sample_t              cur_r_reg,      cur_r_next;
    logic                 fin_reg,        fin_next;

    logic                 v1_reg,         v1_next;
    logic                 run_end1_reg,   run_end1_next;
    logic                 stream_end1_reg, stream_end1_next;
    logic                 out_valid_reg,  out_valid_next;
    result_t              out_reg,        out_next;

    logic                 adv1;
    logic                 adv2;
    logic                 issue;
    logic                 last;
    logic [POS_W-1:0]     pos_sum;
    logic [POS_W-1:0]     pos_wrap;
    sample_t              lane_a_l;
    sample_t              lane_a_r;
    sample_t              y_l;
    sample_t              y_r;

    lri_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline advance
    assign adv2 = !out_valid_reg || result_ready;
    assign adv1 = !v1_reg || adv2;

    assign pos_sum  = pos_reg + cfg.step;
    assign pos_wrap = pos_reg - ONE_POS;

    // frame sequencer
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        have_held_next = have_held_reg;
        held_l_next    = held_l_reg;
        held_r_next    = held_r_reg;
        pre_l_next     = pre_l_reg;
        pre_r_next     = pre_r_reg;
        cur_l_next     = cur_l_reg;
        cur_r_next     = cur_r_reg;
        fin_next       = fin_reg;
        frame_ready    = 1'b0;
        issue          = 1'b0;
        last           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                frame_ready = 1'b1;
                if (frame_valid)
                begin
                    pre_l_next     = held_l_reg;
                    pre_r_next     = held_r_reg;
                    cur_l_next     = frame_data.left_in;
                    cur_r_next     = frame_data.right_in;
                    fin_next       = frame_data.final_frame;
                    pos_next       = POS_W'(phase_reg);
                    have_held_next = !frame_data.final_frame;
                    if (frame_data.final_frame)
                    begin
                        held_l_next = '0;
                        held_r_next = '0;
                        phase_next  = '0;
                    end
                    else
                    begin
                        held_l_next = frame_data.left_in;
                        held_r_next = frame_data.right_in;
                    end
                    priority if (have_held_reg)
                        state_next = ST_SPAN;
                    else if (frame_data.final_frame)
                        state_next = ST_TAIL;
                    else
                        state_next = ST_IDLE;
                end
            end

            ST_SPAN:
            begin
                if (pos_reg < ONE_POS)
                begin
                    if (adv1)
                    begin
                        issue    = 1'b1;
                        last     = (pos_sum >= ONE_POS) && (!fin_reg || pos_sum >= TWO_POS);
                        pos_next = pos_sum;
                    end
                end
                else
                begin
                    pos_next = pos_wrap;
                    if (fin_reg)
                        state_next = ST_TAIL;
                    else
                    begin
                        phase_next = pos_wrap[PHASE_W-1:0];
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_TAIL:
            begin
                if (pos_reg < ONE_POS)
                begin
                    if (adv1)
                    begin
                        issue    = 1'b1;
                        last     = pos_sum >= ONE_POS;
                        pos_next = pos_sum;
                    end
                end
                else
                    state_next = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            phase_reg     <= '0;
            have_held_reg <= 1'b0;
            held_l_reg    <= '0;
            held_r_reg    <= '0;
            fin_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            have_held_reg <= have_held_next;
            held_l_reg    <= held_l_next;
            held_r_reg    <= held_r_next;
            fin_reg       <= fin_next;
        end
    end

    // frame payload
    always_ff @(posedge clk)
    begin
        pre_l_reg <= pre_l_next;
        pre_r_reg <= pre_r_next;
        cur_l_reg <= cur_l_next;
        cur_r_reg <= cur_r_next;
    end

    // lanes: span blends previous into current, tail holds current
    assign lane_a_l = (state_reg == ST_TAIL) ? cur_l_reg : pre_l_reg;
    assign lane_a_r = (state_reg == ST_TAIL) ? cur_r_reg : pre_r_reg;

    lri_lane u_lane_l (
        .clk  (clk),
        .load (issue),
        .a    (lane_a_l),
        .b    (cur_l_reg),
        .frac (pos_reg[FRAC_BITS-1:0]),
        .y    (y_l)
    );

    lri_lane u_lane_r (
        .clk  (clk),
        .load (issue),
        .a    (lane_a_r),
        .b    (cur_r_reg),
        .frac (pos_reg[FRAC_BITS-1:0]),
        .y    (y_r)
    );

    // multiply stage flags
    always_comb
    begin
        v1_next          = v1_reg;
        run_end1_next    = run_end1_reg;
        stream_end1_next = stream_end1_reg;
        if (adv1)
        begin
            v1_next          = issue;
            run_end1_next    = last;
            stream_end1_next = last && fin_reg;
        end
    end

    // merge lanes into the output word
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (adv2)
        begin
            out_valid_next       = v1_reg;
            out_next.left_out    = y_l;
            out_next.right_out   = cfg.stereo ? y_r : sample_t'(0);
            out_next.run_end     = run_end1_reg;
            out_next.stream_end  = stream_end1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_end1_reg    <= run_end1_next;
        stream_end1_reg <= stream_end1_next;
        out_reg         <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

// ----- rtl/core/lri_cfg.sv -----
// lri_cfg: register file behind the APB-style port, with step saturation.
// Depends on lri_pkg.
module lri_cfg
    import lri_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              stereo_reg;
    logic              stereo_next;
    logic              wr_en;
    logic [CMP_W-1:0]  step_ext;
    logic [CMP_W-1:0]  step_sat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_comb
    begin
        step_next   = step_reg;
        stereo_next = stereo_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_STEP:   step_next   = pwdata[STEP_W-1:0];
                REG_STEREO: stereo_next = pwdata[0];
                default:    step_next   = step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_RESET;
            stereo_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            stereo_reg <= stereo_next;
        end
    end

    // read back
    always_comb
    begin
        unique case (paddr[2])
            REG_STEP:   prdata = DATA_W'(step_reg);
            REG_STEREO: prdata = DATA_W'(stereo_reg);
            default:    prdata = '0;
        endcase
    end

    // clamp step into [1/8, 8]
    always_comb
    begin
        step_ext = CMP_W'(step_reg);
        priority if (step_ext < STEP_MIN)
            step_sat = STEP_MIN;
        else if (step_ext > STEP_MAX)
            step_sat = STEP_MAX;
        else
            step_sat = step_ext;
    end

    assign cfg.step   = step_sat[POS_W-1:0];
    assign cfg.stereo = stereo_reg;

endmodule

// ----- rtl/core/lri_lane.sv -----
// lri_lane: one channel of the interpolator, a + trunc((b - a) * frac),
// multiply registered, truncating shift and add after. Depends on lri_pkg.
module lri_lane
    import lri_pkg::*;
(
    input  logic                 clk,
    input  logic                 load,
    input  sample_t              a,
    input  sample_t              b,
    input  logic [FRAC_BITS-1:0] frac,
    output sample_t              y
);

    localparam logic [PROD_W-1:0] ROUND_BIAS = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);

    logic signed [PROD_W-1:0] diff_w;
    logic signed [PROD_W-1:0] frac_w;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    sample_t                  a_reg;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] shifted;

    // difference times fraction
    always_comb
    begin
        diff_w    = PROD_W'(b) - PROD_W'(a);
        frac_w    = $signed(PROD_W'(frac));
        prod_next = diff_w * frac_w;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
            a_reg    <= a;
        end
    end

    // divide by one position, truncating toward zero
    always_comb
    begin
        biased  = prod_reg + (prod_reg[PROD_W-1] ? $signed(ROUND_BIAS) : $signed(PROD_W'(0)));
        shifted = biased >>> FRAC_BITS;
        y       = a_reg + $signed(shifted[SAMPLE_BITS-1:0]);
    end

endmodule
